>>> src/integer_to_ascii_radix_macros.svh
// Assertion macros for the integer to ASCII converter.
// Each macro checks a property on the rising clock edge, held off during reset.
`ifndef INTEGER_TO_ASCII_RADIX_MACROS_SVH
`define INTEGER_TO_ASCII_RADIX_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication.
`define I2A_ASSERT_IMPL(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("same-cycle check failed");

// Next-cycle implication.
`define I2A_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("next-cycle check failed");

`else

`define I2A_ASSERT_IMPL(label, clk, rst_n, lhs, rhs)
`define I2A_ASSERT_NEXT(label, clk, rst_n, lhs, rhs)

`endif

`endif

>>> src/i2a_pkg.sv
package i2a_pkg;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } state_t;

    // Character codes.
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_A     = 8'h41;

    // Accepted radix range.
    localparam logic [4:0] RADIX_MIN = 5'd2;
    localparam logic [4:0] RADIX_MAX = 5'd16;

    // Quotient bits resolved per divider cycle.
    localparam int DIV_STEP = 8;

    // Map a digit value to its uppercase glyph.
    function automatic logic [7:0] digit_glyph(input logic [3:0] d);
        logic [7:0] d8;
        d8 = {4'b0000, d};
        if (d < 4'd10) begin
            return CHAR_ZERO + d8;
        end else begin
            return CHAR_A + d8 - 8'd10;
        end
    endfunction

endpackage

>>> src/integer_to_ascii_radix.sv
// Sequencing: an accepted item is registered, then each digit is resolved in turn by the shared
// 8-bit-per-cycle restoring divider, then the characters enter the output register at one per
// cycle while that register is free or being read. A new item is accepted only while the sequencer
// is idle, after the last character of the previous one. A zero value, or an invalid radix in
// unsigned mode, goes straight to a single zero digit; signed with invalid radix gives no output.
// Reset (aresetn low, synchronous) returns the sequencer to idle and empties the output register.
`include "integer_to_ascii_radix_macros.svh"

module integer_to_ascii_radix #(
    parameter int VALUE_WIDTH    = 32,
    parameter int DIGIT_CAPACITY = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_req_type,
    input  logic [31:0] s_value,
    input  logic [4:0]  s_radix,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_ascii_char,
    output logic        m_last_char
);

    localparam int CHUNKS  = (VALUE_WIDTH + i2a_pkg::DIV_STEP - 1) / i2a_pkg::DIV_STEP;
    localparam int PAD_W   = CHUNKS * i2a_pkg::DIV_STEP;
    localparam int CHUNK_W = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
    localparam int CNT_W   = $clog2(DIGIT_CAPACITY + 1);

    i2a_pkg::state_t state_reg, state_next;
    logic [PAD_W-1:0]   work_reg, work_next;
    logic [3:0]         rem_reg, rem_next;
    logic [CHUNK_W-1:0] chunk_reg, chunk_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               neg_reg, neg_next;
    logic [4:0]         radix_reg, radix_next;
    logic               m_valid_reg, m_valid_next;
    logic [7:0]         m_char_reg, m_char_next;
    logic               m_last_reg, m_last_next;

    logic [3:0] stk_reg [DIGIT_CAPACITY];
    logic       push, pop;
    logic [3:0] push_digit;

    logic [PAD_W-1:0]       div_work;
    logic [3:0]             div_rem;
    logic [VALUE_WIDTH-1:0] v_in, mag_in;
    logic                   radix_ok, neg_in, s_fire, out_free;

    assign s_ready      = (state_reg == i2a_pkg::ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_ascii_char = m_char_reg;
    assign m_last_char  = m_last_reg;

    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // Input decode: width fit, sign and magnitude, radix check.
    assign v_in     = VALUE_WIDTH'(s_value);
    assign neg_in   = s_req_type && v_in[VALUE_WIDTH-1];
    assign mag_in   = neg_in ? ({VALUE_WIDTH{1'b0}} - v_in) : v_in;
    assign radix_ok = (s_radix >= i2a_pkg::RADIX_MIN) && (s_radix <= i2a_pkg::RADIX_MAX);

    // Shared divider: eight restoring steps on a narrow remainder per cycle.
    always_comb begin
        logic [PAD_W-1:0] w;
        logic [3:0]       r;
        logic [4:0]       t;
        w = work_reg;
        r = rem_reg;
        for (int i = 0; i < i2a_pkg::DIV_STEP; i++) begin
            t = {r, w[PAD_W-1]};
            w = {w[PAD_W-2:0], 1'b0};
            if (t >= radix_reg) begin
                t    = t - radix_reg;
                w[0] = 1'b1;
            end
            r = t[3:0];
        end
        div_work = w;
        div_rem  = r;
    end

    // Sequencer: next state, divider control, digit stack and output register.
    always_comb begin
        state_next   = state_reg;
        work_next    = work_reg;
        rem_next     = rem_reg;
        chunk_next   = chunk_reg;
        count_next   = count_reg;
        neg_next     = neg_reg;
        radix_next   = radix_reg;
        m_valid_next = m_valid_reg;
        m_char_next  = m_char_reg;
        m_last_next  = m_last_reg;
        push         = 1'b0;
        pop          = 1'b0;
        push_digit   = 4'd0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            i2a_pkg::ST_IDLE: begin
                if (s_fire && !(s_req_type && !radix_ok)) begin
                    neg_next   = neg_in;
                    radix_next = s_radix;
                    work_next  = PAD_W'(mag_in);
                    rem_next   = 4'd0;
                    chunk_next = '0;
                    if (mag_in == '0 || !radix_ok) begin
                        // Single zero digit.
                        push       = 1'b1;
                        count_next = CNT_W'(1);
                        state_next = i2a_pkg::ST_EMIT;
                    end else begin
                        count_next = '0;
                        state_next = i2a_pkg::ST_DIV;
                    end
                end
            end
            i2a_pkg::ST_DIV: begin
                work_next = div_work;
                rem_next  = div_rem;
                if (chunk_reg == CHUNK_W'(CHUNKS - 1)) begin
                    // One digit finished; the remainder goes on the stack.
                    push       = 1'b1;
                    push_digit = div_rem;
                    count_next = count_reg + 1'b1;
                    chunk_next = '0;
                    rem_next   = 4'd0;
                    if (div_work == '0 || count_reg == CNT_W'(DIGIT_CAPACITY - 1)) begin
                        state_next = i2a_pkg::ST_EMIT;
                    end
                end else begin
                    chunk_next = chunk_reg + 1'b1;
                end
            end
            i2a_pkg::ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (neg_reg) begin
                        m_char_next = i2a_pkg::CHAR_MINUS;
                        m_last_next = 1'b0;
                        neg_next    = 1'b0;
                    end else begin
                        pop         = 1'b1;
                        m_char_next = i2a_pkg::digit_glyph(stk_reg[0]);
                        m_last_next = (count_reg == CNT_W'(1));
                        count_next  = count_reg - 1'b1;
                        if (count_reg == CNT_W'(1)) begin
                            state_next = i2a_pkg::ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                state_next = i2a_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= i2a_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
            count_reg   <= '0;
            chunk_reg   <= '0;
            neg_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            count_reg   <= count_next;
            chunk_reg   <= chunk_next;
            neg_reg     <= neg_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        work_reg   <= work_next;
        rem_reg    <= rem_next;
        radix_reg  <= radix_next;
        m_char_reg <= m_char_next;
        m_last_reg <= m_last_next;
    end

    // Digit stack: push enters at the bottom, pop reads the bottom.
    always_ff @(posedge aclk) begin
        if (push) begin
            stk_reg[0] <= push_digit;
            for (int i = 1; i < DIGIT_CAPACITY; i++) begin
                stk_reg[i] <= stk_reg[i-1];
            end
        end else if (pop) begin
            for (int i = 0; i < DIGIT_CAPACITY - 1; i++) begin
                stk_reg[i] <= stk_reg[i+1];
            end
            stk_reg[DIGIT_CAPACITY-1] <= 4'd0;
        end
    end

    // Checks.
    `I2A_ASSERT_IMPL(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CNT_W'(DIGIT_CAPACITY))
    `I2A_ASSERT_IMPL(a_emit_has_digit, aclk, aresetn, state_reg == i2a_pkg::ST_EMIT, count_reg != '0)
    `I2A_ASSERT_IMPL(a_sign_not_last, aclk, aresetn, m_valid && m_last_char, m_ascii_char != i2a_pkg::CHAR_MINUS)
    `I2A_ASSERT_NEXT(a_signed_bad_radix, aclk, aresetn, s_fire && s_req_type && !radix_ok, state_reg == i2a_pkg::ST_IDLE)

endmodule

>>> tb/integer_to_ascii_radix_tb.sv
module integer_to_ascii_radix_tb;

    // Receiver hold-off used to back the block up against its input.
    localparam int HOLD_CYCLES  = 1500;
    // Cycles allowed after the last expected character for stray output.
    localparam int DRAIN_CYCLES = 250;
    localparam int RANDOM_ITEMS = 250;

    // Digit glyphs, digit 0 in the top byte.
    localparam logic [8*16-1:0] GLYPHS = "0123456789ABCDEF";

    typedef struct packed {
        logic [7:0] ascii;
        logic       last;
    } text_char_t;

    logic        aclk         = 1'b0;
    logic        aresetn      = 1'b0;
    logic        s_valid      = 1'b0;
    logic        s_ready;
    logic        s_req_type   = 1'b0;
    logic [31:0] s_value      = 32'd0;
    logic [4:0]  s_radix      = 5'd0;
    logic        m_valid;
    logic        m_ready      = 1'b0;
    logic [7:0]  m_ascii_char;
    logic        m_last_char;

    // Characters still owed by the block, oldest first.
    text_char_t char_q[$];
    text_char_t oldest_char;
    int         fail_count     = 0;
    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;
    bit         hold_req       = 1'b0;

    // Directed stimulus table; text is typed only where obvious.
    logic        dir_req[$];
    logic [31:0] dir_value[$];
    logic [4:0]  dir_radix[$];
    bit          dir_known[$];
    string       dir_text[$];

    integer_to_ascii_radix uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_value      (s_value),
        .s_radix      (s_radix),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_ascii_char (m_ascii_char),
        .m_last_char  (m_last_char)
    );

    initial begin
        forever begin
            #2 aclk = ~aclk;
        end
    end

    // Hard limit on the run.
    initial begin
        #4000000;
        $display("*** FAILED ***");
        $finish;
    end

    // Work out the characters of one conversion and queue them.
    function automatic void predict_text(input logic signed_req, input logic [31:0] val,
                                         input logic [4:0] base);
        logic [31:0] mag;
        logic [31:0] digit;
        logic [7:0]  glyphs[$];
        bit          base_ok;
        base_ok = (base >= i2a_pkg::RADIX_MIN) && (base <= i2a_pkg::RADIX_MAX);
        mag = val;
        if (signed_req) begin
            // A bad base in signed mode yields no text at all.
            if (!base_ok) begin
                return;
            end
            if (val[31]) begin
                char_q.push_back('{ascii: i2a_pkg::CHAR_MINUS, last: 1'b0});
                mag = 32'd0 - val;
            end
        end
        if (mag == 32'd0 || !base_ok) begin
            char_q.push_back('{ascii: i2a_pkg::CHAR_ZERO, last: 1'b1});
            return;
        end
        // Peel digits off the low end, then emit high end first.
        while (mag != 32'd0) begin
            digit = mag % {27'd0, base};
            glyphs.push_front(GLYPHS[8*(15 - digit[3:0]) +: 8]);
            mag = mag / {27'd0, base};
        end
        for (int i = 0; i < glyphs.size(); i++) begin
            char_q.push_back('{ascii: glyphs[i], last: (i == glyphs.size() - 1)});
        end
    endfunction

    task automatic add_row(input logic rt, input logic [31:0] v, input logic [4:0] r,
                           input bit known, input string text);
        dir_req.push_back(rt);
        dir_value.push_back(v);
        dir_radix.push_back(r);
        dir_known.push_back(known);
        dir_text.push_back(text);
    endtask

    // Offer one item, wait for it to be taken, then record what it owes.
    task automatic send_item(input logic rt, input logic [31:0] v, input logic [4:0] r,
                             input bit known, input string text);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_req_type <= rt;
        s_value    <= v;
        s_radix    <= r;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (known) begin
            for (int i = 0; i < text.len(); i++) begin
                char_q.push_back('{ascii: text[i], last: (i == text.len() - 1)});
            end
        end else begin
            predict_text(rt, v, r);
        end
    endtask

    // Receiver: random stalls, plus one long hold-off on request.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Compare each accepted character with the oldest one owed.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (char_q.size() == 0) begin
                $error("unexpected character item 0x%02h last %0b", m_ascii_char, m_last_char);
                fail_count++;
            end else begin
                oldest_char = char_q.pop_front();
                if (m_ascii_char !== oldest_char.ascii) begin
                    $error("ascii_char mismatch: expected 0x%02h, got 0x%02h",
                           oldest_char.ascii, m_ascii_char);
                    fail_count++;
                end
                if (m_last_char !== oldest_char.last) begin
                    $error("last_char mismatch: expected %0b, got %0b",
                           oldest_char.last, m_last_char);
                    fail_count++;
                end
            end
        end
    end

    initial begin : stimulus
        logic        rt;
        logic [31:0] v;
        logic [4:0]  r;
        int          pick;

        // Extremes, bad bases in both modes and the most negative value.
        add_row(1'b0, 32'h0000_0000, 5'd10, 1'b1, "0");
        add_row(1'b0, 32'hFFFF_FFFF, 5'd16, 1'b1, "FFFFFFFF");
        add_row(1'b0, 32'hFFFF_FFFF, 5'd2,  1'b1, "11111111111111111111111111111111");
        add_row(1'b1, 32'h8000_0000, 5'd16, 1'b1, "-80000000");
        add_row(1'b1, 32'h8000_0000, 5'd2,  1'b0, "");
        add_row(1'b1, 32'hFFFF_FFFF, 5'd10, 1'b1, "-1");
        add_row(1'b1, 32'h7FFF_FFFF, 5'd16, 1'b1, "7FFFFFFF");
        add_row(1'b0, 32'h0000_0005, 5'd0,  1'b1, "0");
        add_row(1'b0, 32'h0000_0005, 5'd1,  1'b1, "0");
        add_row(1'b0, 32'h0000_0005, 5'd17, 1'b1, "0");
        add_row(1'b0, 32'hFFFF_FFFF, 5'd31, 1'b1, "0");
        add_row(1'b1, 32'h0000_0005, 5'd0,  1'b1, "");
        add_row(1'b1, 32'h8000_0000, 5'd31, 1'b1, "");
        add_row(1'b1, 32'h0000_0000, 5'd1,  1'b1, "");
        add_row(1'b1, 32'h0000_0000, 5'd10, 1'b1, "0");
        add_row(1'b0, 32'hFFFF_FFFF, 5'd10, 1'b1, "4294967295");
        add_row(1'b0, 32'hFFFF_FFFF, 5'd3,  1'b0, "");
        add_row(1'b0, 32'h1234_5678, 5'd16, 1'b1, "12345678");
        add_row(1'b0, 32'hABCD_EF01, 5'd16, 1'b1, "ABCDEF01");
        add_row(1'b0, 32'h0000_0001, 5'd2,  1'b1, "1");
        add_row(1'b0, 32'h0000_000F, 5'd16, 1'b1, "F");
        add_row(1'b0, 32'h0000_0010, 5'd16, 1'b1, "10");
        add_row(1'b1, 32'h8000_0000, 5'd10, 1'b1, "-2147483648");
        add_row(1'b0, 32'h8000_0000, 5'd8,  1'b0, "");
        add_row(1'b1, 32'hDEAD_BEEF, 5'd7,  1'b0, "");

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < dir_req.size(); i++) begin
            send_item(dir_req[i], dir_value[i], dir_radix[i], dir_known[i], dir_text[i]);
        end

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            // Idling profile changes every fifty items.
            case (i / 50)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
                3: begin send_idle_pct = 27; recv_stall_pct = 27; end
                default: begin send_idle_pct = 0; recv_stall_pct = 10; end
            endcase
            // Back the block up, and later let it run dry.
            if (i == 200) begin
                hold_req = 1'b1;
            end
            if (i == 225) begin
                s_valid <= 1'b0;
                @(posedge aclk);
                while (char_q.size() != 0) @(posedge aclk);
            end

            rt = 1'($urandom_range(1));
            pick = $urandom_range(99);
            if (pick < 8) begin
                r = $urandom_range(1) ? 5'($urandom_range(1)) : 5'($urandom_range(31, 17));
            end else begin
                r = 5'($urandom_range(16, 2));
            end
            pick = $urandom_range(9);
            case (pick)
                0: v = $urandom_range(15);
                1: begin
                    case ($urandom_range(3))
                        0: v = 32'h0000_0000;
                        1: v = 32'hFFFF_FFFF;
                        2: v = 32'h8000_0000;
                        default: v = 32'h7FFF_FFFF;
                    endcase
                end
                2: v = $urandom_range(255);
                3: v = 32'd0 - $urandom_range(255);
                default: v = $urandom;
            endcase
            send_item(rt, v, r, 1'b0, "");
        end
        s_valid <= 1'b0;

        // Let everything owed arrive, then watch for stray output.
        while (char_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
